>>> rtl/core/atar_pkg.sv
// shared types, constants and encodings for the associative tag table
// no dependencies; used by every module in rtl/core except atar_ram
package atar_pkg;

    // table geometry defaults and fixed field widths
    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 64;
    localparam int SLOT_W      = 4;

    // request modes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // request and response beats
    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              replaced_valid;
    } rsp_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic fin_hit;
        logic fin_miss;
        logic fin_ins;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic match;
        logic last;
    } sts_t;

endpackage

>>> rtl/core/atar_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module atar_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/atar_ctrl.sv
// controller state machine for lookup scans and inserts
// depends on atar_pkg
module atar_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          mode,
    input  atar_pkg::sts_t sts,
    output logic          busy,
    output atar_pkg::cmd_t cmd
);

    atar_pkg::state_t state_reg;
    atar_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atar_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atar_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == atar_pkg::MODE_INSERT)
                    begin
                        state_next = atar_pkg::ST_INSERT;
                    end
                    else
                    begin
                        state_next = atar_pkg::ST_SCAN;
                    end
                end
            end
            atar_pkg::ST_SCAN:
            begin
                if (sts.empty || sts.match || sts.last)
                begin
                    state_next = atar_pkg::ST_IDLE;
                end
            end
            atar_pkg::ST_INSERT:
            begin
                state_next = atar_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = atar_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            atar_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            atar_pkg::ST_SCAN:
            begin
                priority if (sts.match)
                begin
                    cmd.fin_hit = 1'b1;
                end
                else if (sts.empty || sts.last)
                begin
                    cmd.fin_miss = 1'b1;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            atar_pkg::ST_INSERT:
            begin
                cmd.fin_ins = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/atar_dp.sv
// datapath: key ram, fill count, replacement pointer, scan pipe, response register
// depends on atar_pkg and atar_ram
module atar_dp #(
    parameter int ENTRIES = atar_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  atar_pkg::req_t req,
    input  atar_pkg::cmd_t cmd,
    output atar_pkg::sts_t sts,
    output logic           done,
    output atar_pkg::rsp_t rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // every insert fills the lowest empty slot, so the valid slots are always
    // 0..count-1; once full, the oldest insert is the next slot in round robin,
    // which is what the replacement pointer selects
    logic [CW-1:0]            count_reg;
    logic [IW-1:0]            ptr_reg;
    logic [atar_pkg::KEY_W-1:0] key_reg;
    logic [IW-1:0]            scan_idx_reg;
    logic [IW-1:0]            cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic                     done_reg;
    atar_pkg::rsp_t           rsp_reg;
    logic [atar_pkg::KEY_W-1:0] rd_data;
    logic                     full;

    assign full = (count_reg == FULL_CNT);

    // key store
    atar_ram #(
        .WIDTH (atar_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.fin_ins),
        .waddr (ptr_reg),
        .wdata (key_reg),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    // status back to the controller
    assign sts.empty = (count_reg == '0);
    assign sts.match = cmp_vld_reg && (rd_data == key_reg);
    assign sts.last  = cmp_vld_reg && ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);

    // request capture and scan pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
            cmp_idx_reg  <= scan_idx_reg;
            cmp_vld_reg  <= 1'b1;
        end
        else
        begin
            cmp_vld_reg <= 1'b0;
        end
    end

    // key of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= req.key;
        end
    end

    // fill count and replacement pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (cmd.fin_ins)
        begin
            if (!full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (ptr_reg == LAST_IDX)
            begin
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + IW'(1);
            end
        end
    end

    // response strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin_hit | cmd.fin_miss | cmd.fin_ins;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (cmd.fin_hit)
        begin
            rsp_reg.hit            <= 1'b1;
            rsp_reg.slot           <= atar_pkg::SLOT_W'(cmp_idx_reg);
            rsp_reg.replaced_valid <= 1'b0;
        end
        else if (cmd.fin_ins)
        begin
            rsp_reg.hit            <= 1'b0;
            rsp_reg.slot           <= atar_pkg::SLOT_W'(ptr_reg);
            rsp_reg.replaced_valid <= full;
        end
        else if (cmd.fin_miss)
        begin
            rsp_reg <= '0;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/core/assoc_tag_table_age_replace.sv
// top level of the fully associative tag table with oldest-insert replacement
// depends on atar_pkg, atar_ctrl, atar_dp (which holds atar_ram)
//
//  beat      | ports             | handshake
//  ----------+-------------------+------------------------------------
//  request   | req (mode, key)   | taken when start is high, busy low
//  response  | rsp (hit, slot,   | done high for one cycle, always taken
//            |  replaced_valid)  |
//
// an insert passes from accept through ST_INSERT and the done register to done;
// a lookup walks the key ram one slot per cycle, reading at most ENTRIES slots,
// a rate set by the single read port of the key ram.
// reset empties the table at once; no clearing pass is needed.
// busy drops as the response is being formed, so a new request can be
// taken in the same cycle that done is high.
module assoc_tag_table_age_replace #(
    parameter int ENTRIES = atar_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  atar_pkg::req_t req,
    output logic           done,
    output atar_pkg::rsp_t rsp
);

    atar_pkg::cmd_t cmd;
    atar_pkg::sts_t sts;

    // controller
    atar_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (req.mode),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath
    atar_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
